@@ rtl/slsm_pkg.sv @@
package slsm_pkg;

	localparam int PAT_MAX    = 32;
	localparam int PAT_IDX_W  = $clog2(PAT_MAX);
	localparam int PAT_LEN_W  = 6;
	localparam int PAT_WORDS  = 4;
	localparam int LINE_LEN_W = 16;
	localparam int LEN_CNT_W  = LINE_LEN_W + 1;
	localparam int LINE_NUM_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic {
		OP_DATA   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LEN  = 3'd0,
		REG_PAT_W0   = 3'd1,
		REG_PAT_W1   = 3'd2,
		REG_PAT_W2   = 3'd3,
		REG_PAT_W3   = 3'd4,
		REG_MAX_LINE = 3'd5
	} reg_idx_t;

	typedef logic [PAT_MAX-1:0][7:0] byte_vec_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} text_item_t;

	typedef struct packed {
		logic [LINE_NUM_W-1:0] line_number;
		logic                  line_matched;
		logic                  line_too_long;
		logic                  long_seen;
	} result_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_item_t;

	// compare status from the window matcher
	typedef struct packed {
		logic window_hit;
		logic pat_has_nl;
	} match_t;

endpackage

@@ rtl/slsm_if.sv @@
interface slsm_text_if;
	import slsm_pkg::*;
	logic       valid;
	logic       ready;
	text_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slsm_result_if;
	import slsm_pkg::*;
	logic         valid;
	logic         ready;
	result_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slsm_cfg_if;
	import slsm_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/streaming_line_substring_matcher_top.sv @@
// Fixed-string line matcher.
// text:   input beats, one byte per beat; operation finish flushes a pending
//         partial line, a newline byte ends the current line.
// result: one beat per ended line: line number (saturating), matched,
//         too-long, and the sticky too-long flag.
// cfg:    register writes (pattern length, four pattern words, line limit);
//         always ready; the user must write only while no line result is
//         outstanding, as the block does not enforce it.
// A line end loads the result register from the input register. The rate
// is one byte per cycle while no line end waits on a held result: each byte
// sits in one input register while the 32-byte window compare against the
// pattern and line bookkeeping settle, then state and result registers load.
// When the receiver stalls, the result register holds its beat; the input
// register still takes bytes that end no line, and stops at the next line
// end until the result register frees up.
// Reset clears the window, line length, hit, line counter and sticky flag;
// pattern length and words reset to zero, the line limit to 65535.
module streaming_line_substring_matcher_top (
	input  logic            clk,
	input  logic            arst_n,
	slsm_text_if.sink       text,
	slsm_result_if.source   result,
	slsm_cfg_if.sink        cfg
);
	import slsm_pkg::*;

	// configuration
	logic [PAT_LEN_W-1:0]                  pat_len_q;
	logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pat_words_q;
	logic [LINE_LEN_W-1:0]                 max_line_q;

	// line state
	byte_vec_t              window_q;
	logic [LEN_CNT_W-1:0]   len_q;
	logic                   hit_q;
	logic [LINE_NUM_W-1:0]  cnt_q;
	logic                   long_q;

	// input and result registers
	logic                   valid_s1;
	text_item_t             item_s1;
	logic                   res_valid_q;
	result_item_t           res_q;

	byte_vec_t              pattern;
	byte_vec_t              win_next;
	match_t                 mstat;
	logic [LINE_LEN_W-1:0]  limit;
	logic                   len_ok;
	logic [LEN_CNT_W-1:0]   len_next;
	logic                   is_finish;
	logic                   is_nl;
	logic                   ends_line;
	logic                   adv;
	logic                   too_long;
	logic [LINE_NUM_W-1:0]  cnt_next;
	logic [PAT_LEN_W-1:0]   n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q   <= '0;
			pat_words_q <= '0;
			max_line_q  <= '1;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_PAT_LEN:  pat_len_q      <= cfg.data.wdata[PAT_LEN_W-1:0];
				REG_PAT_W0:   pat_words_q[0] <= cfg.data.wdata;
				REG_PAT_W1:   pat_words_q[1] <= cfg.data.wdata;
				REG_PAT_W2:   pat_words_q[2] <= cfg.data.wdata;
				REG_PAT_W3:   pat_words_q[3] <= cfg.data.wdata;
				REG_MAX_LINE: max_line_q     <= cfg.data.wdata[LINE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern  = pat_words_q;
	assign limit    = (max_line_q == '0) ? LINE_LEN_W'(1) : max_line_q;
	assign len_ok   = (len_q <= {1'b0, limit});
	assign len_next = len_ok ? len_q + LEN_CNT_W'(1) : len_q;
	assign win_next = {window_q[PAT_MAX-2:0], item_s1.data_byte};
	assign n        = (pat_len_q > PAT_LEN_W'(PAT_MAX)) ? PAT_LEN_W'(PAT_MAX) : pat_len_q;

	slsm_match u_match (
		.window  (win_next),
		.pattern (pattern),
		.pat_len (pat_len_q),
		.status  (mstat)
	);

	assign is_finish = (item_s1.operation == OP_FINISH);
	assign is_nl     = (item_s1.data_byte == NEWLINE_BYTE);
	assign ends_line = is_finish ? (len_q != '0) : is_nl;
	assign too_long  = (len_q > {1'b0, limit});
	assign cnt_next  = (cnt_q != '1) ? cnt_q + LINE_NUM_W'(1) : cnt_q;

	// a byte that ends no line never needs the result register
	assign adv        = valid_s1 && (!ends_line || !res_valid_q || result.ready);
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1 <= text.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			len_q    <= '0;
			hit_q    <= 1'b0;
			cnt_q    <= '0;
			long_q   <= 1'b0;
		end else if (adv) begin
			if (ends_line) begin
				len_q  <= '0;
				hit_q  <= 1'b0;
				cnt_q  <= cnt_next;
				long_q <= long_q | too_long;
			end else if (!is_finish) begin
				window_q <= win_next;
				len_q    <= len_next;
				if (mstat.window_hit && (len_next <= {1'b0, limit})
				    && (len_next >= LEN_CNT_W'(n))) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && ends_line) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ends_line) begin
			res_q.line_number   <= cnt_next;
			res_q.line_matched  <= !too_long && !mstat.pat_has_nl && ((n == '0) || hit_q);
			res_q.line_too_long <= too_long;
			res_q.long_seen     <= long_q | too_long;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_hit_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (len_q != '0))
		else $error("line hit set with empty line");

	a_line_num_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.line_number != '0))
		else $error("result beat with line number zero");

	a_match_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.line_matched && res_q.line_too_long))
		else $error("too-long line reported as matched");

	a_sticky_long: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.line_too_long) |-> (res_q.long_seen && long_q))
		else $error("sticky too-long flag missing");

endmodule

@@ rtl/slsm_match.sv @@
module slsm_match (
	input  slsm_pkg::byte_vec_t             window,
	input  slsm_pkg::byte_vec_t             pattern,
	input  logic [slsm_pkg::PAT_LEN_W-1:0]  pat_len,
	output slsm_pkg::match_t                status
);
	import slsm_pkg::*;

	logic [PAT_LEN_W-1:0] n;
	logic [PAT_MAX-1:0]   eq;
	logic [PAT_MAX-1:0]   nl;

	assign n = (pat_len > PAT_LEN_W'(PAT_MAX)) ? PAT_LEN_W'(PAT_MAX) : pat_len;

	// pattern byte k lines up with window byte n-1-k (window index 0 is newest)
	always_comb begin
		logic [PAT_LEN_W-1:0] idx;
		for (int k = 0; k < PAT_MAX; k++) begin
			idx = n - PAT_LEN_W'(1) - PAT_LEN_W'(k);
			if (PAT_LEN_W'(k) < n) begin
				eq[k] = (window[idx[PAT_IDX_W-1:0]] == pattern[k]);
				nl[k] = (pattern[k] == NEWLINE_BYTE);
			end else begin
				eq[k] = 1'b1;
				nl[k] = 1'b0;
			end
		end
	end

	assign status.window_hit = (n != '0) && (&eq);
	assign status.pat_has_nl = |nl;

endmodule

@@ tb/streaming_line_substring_matcher_top_test.sv @@
`timescale 1ns / 100ps

module streaming_line_substring_matcher_top_test;
	import slsm_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 150;
	localparam int SETTLE       = 4;

	logic clk;
	logic arst_n;

	slsm_text_if   text_ch ();
	slsm_result_if result_ch ();
	slsm_cfg_if    cfg_ch ();

	streaming_line_substring_matcher_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	text_item_t   pending_text [$];
	result_item_t expected_lines [$];
	int unsigned  queued_count;
	int unsigned  accepted_count;
	int unsigned  src_idle_pct;
	int unsigned  snk_stall_pct;
	int unsigned  fail_count;
	int unsigned  cycle_count = 0;

	// register mirror
	logic [PAT_LEN_W-1:0]  cfg_pat_len;
	logic [CFG_DATA_W-1:0] cfg_words [PAT_WORDS];
	logic [LINE_LEN_W-1:0] cfg_max_line;

	// line state mirror
	logic [7:0]            win_bytes [PAT_MAX];
	int unsigned           cur_len;
	bit                    cur_hit;
	logic [LINE_NUM_W-1:0] lines_done;
	bit                    any_long;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pat_span();
		return (cfg_pat_len > PAT_MAX) ? PAT_MAX : int'(cfg_pat_len);
	endfunction

	function automatic logic [7:0] pat_at(int k);
		return cfg_words[k / 8][(k % 8) * 8 +: 8];
	endfunction

	function automatic int unsigned line_cap();
		return (cfg_max_line == 0) ? 1 : cfg_max_line;
	endfunction

	task automatic close_line();
		int n;
		bit too_long;
		bit has_nl;
		bit matched;
		result_item_t entry;
		n = pat_span();
		too_long = cur_len > line_cap();
		has_nl = 1'b0;
		for (int k = 0; k < n; k++)
			if (pat_at(k) == NEWLINE_BYTE)
				has_nl = 1'b1;
		matched = !too_long && !has_nl && (n == 0 || cur_hit);
		if (lines_done != '1)
			lines_done++;
		if (too_long)
			any_long = 1'b1;
		entry = '{lines_done, matched, too_long, any_long};
		expected_lines = {expected_lines, entry};
		cur_len = 0;
		cur_hit = 1'b0;
	endtask

	task automatic take_text(text_item_t it);
		int n;
		bit same;
		if (it.operation == OP_FINISH) begin
			if (cur_len != 0)
				close_line();
		end else if (it.data_byte == NEWLINE_BYTE) begin
			close_line();
		end else begin
			if (cur_len <= line_cap())
				cur_len++;
			for (int k = PAT_MAX - 1; k > 0; k--)
				win_bytes[k] = win_bytes[k - 1];
			win_bytes[0] = it.data_byte;
			n = pat_span();
			if (n > 0 && cur_len <= line_cap() && cur_len >= n) begin
				same = 1'b1;
				// oldest window byte lines up with pattern byte 0
				for (int k = 0; k < n; k++)
					if (win_bytes[n - 1 - k] != pat_at(k))
						same = 1'b0;
				if (same)
					cur_hit = 1'b1;
			end
		end
	endtask

	// text driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.data  <= '0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				take_text(text_ch.data);
				accepted_count++;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (pending_text.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					text_ch.valid <= 1'b1;
					text_ch.data  <= pending_text.pop_front();
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		result_item_t want;
		result_item_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_lines.size() == 0) begin
				fail_count++;
				$display("%0t: result with none expected: line %0d matched %0b long %0b seen %0b",
					$time, got.line_number, got.line_matched, got.line_too_long, got.long_seen);
			end else begin
				want = expected_lines.pop_front();
				if (got.line_number !== want.line_number || got.line_matched !== want.line_matched ||
						got.line_too_long !== want.line_too_long ||
						got.long_seen !== want.long_seen) begin
					fail_count++;
					$display("%0t: mismatch expected line %0d matched %0b long %0b seen %0b",
						$time, want.line_number, want.line_matched, want.line_too_long,
						want.long_seen);
					$display("%0t:          actual   line %0d matched %0b long %0b seen %0b",
						$time, got.line_number, got.line_matched, got.line_too_long,
						got.long_seen);
				end
			end
		end
	end

	task automatic queue_item(logic op, logic [7:0] b);
		text_item_t it;
		it = '{op, b};
		pending_text = {pending_text, it};
		queued_count++;
	endtask

	task automatic queue_text(string s);
		foreach (s[i])
			queue_item(OP_DATA, s[i]);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{idx, value};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_PAT_LEN:  cfg_pat_len = value[PAT_LEN_W-1:0];
			REG_PAT_W0:   cfg_words[0] = value;
			REG_PAT_W1:   cfg_words[1] = value;
			REG_PAT_W2:   cfg_words[2] = value;
			REG_PAT_W3:   cfg_words[3] = value;
			REG_MAX_LINE: cfg_max_line = value[LINE_LEN_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper bits of the length and limit writes carry noise
	task automatic configure(logic [PAT_LEN_W-1:0] len, logic [CFG_DATA_W-1:0] w0,
			logic [CFG_DATA_W-1:0] w1, logic [CFG_DATA_W-1:0] w2, logic [CFG_DATA_W-1:0] w3,
			logic [LINE_LEN_W-1:0] max_line);
		logic [CFG_DATA_W-1:0] v;
		v = {$urandom(), $urandom()};
		v[PAT_LEN_W-1:0] = len;
		write_reg(REG_PAT_LEN, v);
		write_reg(REG_PAT_W0, w0);
		write_reg(REG_PAT_W1, w1);
		write_reg(REG_PAT_W2, w2);
		write_reg(REG_PAT_W3, w3);
		v = {$urandom(), $urandom()};
		v[LINE_LEN_W-1:0] = max_line;
		write_reg(REG_MAX_LINE, v);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (accepted_count != queued_count || expected_lines.size() != 0);
		// trailing data bytes end no line but may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random_phase(int p);
		logic [7:0]            pat [PAT_MAX];
		logic [CFG_DATA_W-1:0] words [PAT_WORDS];
		logic [7:0]            chars [$];
		logic [PAT_LEN_W-1:0]  len;
		logic [LINE_LEN_W-1:0] max_line;
		int unsigned n, upper, span, pos, added;
		logic [7:0] b;

		case (p)
			0: begin len = 3;  max_line = 16'hFFFF; end
			1: begin len = 0;  max_line = LINE_LEN_W'($urandom_range(30, 2)); end
			2: begin len = 1;  max_line = 0; end
			3: begin len = 32; max_line = 16'hFFFF; end
			4: begin len = 63; max_line = 40; end
			5: begin len = 2;  max_line = 1; end
			6: begin len = 5;  max_line = LINE_LEN_W'($urandom_range(40, 2)); end
			default: begin
				len = PAT_LEN_W'($urandom_range(63));
				max_line = LINE_LEN_W'($urandom_range(40, 1));
			end
		endcase
		for (int k = 0; k < PAT_MAX; k++)
			pat[k] = ($urandom_range(99) < 85) ? 8'(8'h61 + $urandom_range(2))
				: 8'($urandom_range(255));
		n = (len > PAT_MAX) ? PAT_MAX : len;
		if (n > 0 && $urandom_range(5) == 0)
			pat[$urandom_range(n - 1)] = NEWLINE_BYTE;
		for (int w = 0; w < PAT_WORDS; w++)
			for (int k = 0; k < 8; k++)
				words[w][k * 8 +: 8] = pat[w * 8 + k];
		configure(len, words[0], words[1], words[2], words[3], max_line);

		case (p % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0; end
			1: begin src_idle_pct = 45; snk_stall_pct = 0; end
			2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
			default: begin src_idle_pct = 35; snk_stall_pct = 35; end
		endcase

		upper = (line_cap() + 2 > 40) ? 40 : line_cap() + 2;
		added = 0;
		while (added < PHASE_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				queue_item(1'($urandom_range(1)), 8'($urandom_range(255)));
				added++;
			end else begin
				span = $urandom_range(upper);
				chars = {};
				for (int k = 0; k < span; k++) begin
					b = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
						: 8'(8'h61 + $urandom_range(2));
					chars = {chars, ((b == NEWLINE_BYTE) ? 8'h20 : b)};
				end
				if (n > 0 && n <= span && $urandom_range(1)) begin
					pos = $urandom_range(span - n);
					for (int k = 0; k < n; k++)
						chars[pos + k] = pat[k];
				end
				foreach (chars[i])
					queue_item(OP_DATA, chars[i]);
				if ($urandom_range(99) < 85)
					queue_item(OP_DATA, NEWLINE_BYTE);
				else
					queue_item(OP_FINISH, 8'($urandom_range(255)));
				added += span + 1;
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		queued_count = 0;
		accepted_count = 0;
		fail_count = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		cfg_pat_len = '0;
		cfg_words = '{default: '0};
		cfg_max_line = 16'hFFFF;
		win_bytes = '{default: 8'h00};
		cur_len = 0;
		cur_hit = 1'b0;
		lines_done = '0;
		any_long = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pattern matches every line
		queue_text("\n");
		queue_item(OP_FINISH, 8'hFF);
		queue_item(OP_DATA, 8'h00);
		queue_item(OP_DATA, 8'hFF);
		queue_item(OP_FINISH, 8'h5A);
		drain();

		// "abc" with a four byte limit: hit, overlong line, partial line flushed
		configure(3, 64'h0000_0000_0063_6261, '0, '0, '0, 4);
		queue_text("xabc\n");
		queue_text("abcde\n");
		queue_text("ab");
		queue_item(OP_FINISH, 8'hA5);
		drain();

		// length beyond the window, all-ones pattern, zero limit
		configure(63, '1, '1, '1, '1, 0);
		queue_item(OP_DATA, 8'hFF);
		queue_item(OP_DATA, NEWLINE_BYTE);
		queue_item(OP_DATA, 8'hFF);
		queue_item(OP_DATA, 8'hFF);
		queue_item(OP_DATA, NEWLINE_BYTE);
		drain();

		// pattern of a single newline never matches
		configure(1, 64'h0A, '0, '0, '0, 16'hFFFF);
		queue_text("a\n");
		drain();

		for (int p = 0; p < 8; p++)
			run_random_phase(p);

		if (expected_lines.size() != 0) begin
			fail_count += expected_lines.size();
			$display("%0t: %0d expected lines never reported", $time, expected_lines.size());
		end
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/slsm_pkg.sv
rtl/slsm_if.sv
rtl/slsm_match.sv
rtl/streaming_line_substring_matcher_top.sv
tb/streaming_line_substring_matcher_top_test.sv
